[rtl/sal_pkg.sv]
// ----------------------------------------------------------------------------
// sal_pkg
// Types and codes shared by the shift array list and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package sal_pkg;

    typedef enum logic [2:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_POP_BACK   = 3'd1,
        CMD_PUSH_FRONT = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_INSERT     = 3'd4,
        CMD_ERASE      = 3'd5,
        CMD_READ       = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADIDX = 2'd3
    } status_t;

    // per-cell action, broadcast along the chain
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } cell_op_t;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [6:0]         position;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [6:0]         count;
        logic [1:0]         status;
    } out_item_t;

endpackage

`default_nettype wire

[rtl/sal_if.sv]
// ----------------------------------------------------------------------------
// sal_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface sal_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/sal_cell.sv]
// ----------------------------------------------------------------------------
// sal_cell
// One list slot: holds a word, shifts from either neighbour or loads a new word.
// ----------------------------------------------------------------------------
`default_nettype none

module sal_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int IDX_W      = 6,
    parameter int INDEX      = 0
) (
    input  wire                     clk,
    input  sal_pkg::cell_op_t       op,
    input  wire [IDX_W-1:0]         idx,
    input  wire [DATA_WIDTH-1:0]    word,
    input  wire [DATA_WIDTH-1:0]    left,
    input  wire [DATA_WIDTH-1:0]    right,
    output logic [DATA_WIDTH-1:0]   data,
    output logic [DATA_WIDTH-1:0]   rd_data
);
    import sal_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  hit;
    logic                  above;

    assign hit   = (idx == MY_IDX);
    assign above = (MY_IDX > idx);

    always_comb
    begin
        data_next = data_reg;
        case (op)
            CELL_INSERT:
            begin
                if (hit)
                begin
                    data_next = word;
                end
                else if (above)
                begin
                    data_next = left;
                end
            end
            CELL_REMOVE:
            begin
                // everything from the gap upwards moves down one place
                if (hit || above)
                begin
                    data_next = right;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = hit ? data_reg : '0;

endmodule

`default_nettype wire

[rtl/shift_array_list.sv]
// ----------------------------------------------------------------------------
// shift_array_list
// Bounded ordered list of words kept in a chain of shift cells.
// ----------------------------------------------------------------------------
// result: written to the output register on the request transfer
// throughput: one command per cycle while rsp.ready holds; every cell shifts
//   in the same cycle, so insert and erase cost no more than a push
// the result register is freed in the cycle it is taken, so requests keep flowing
// reset: element count cleared, output register empty; cell contents undefined
`default_nettype none

module shift_array_list #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire    clk,
    input  wire    rst_n,
    sal_if.sink    req,
    sal_if.source  rsp
);
    import sal_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  out_valid_reg;
    out_item_t             out_reg;

    logic                  accept;
    cmd_t                  cmd;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      cnt_ext;
    logic                  full;
    logic                  empty;
    cell_op_t              op;
    cell_op_t              cell_op;
    logic [IDX_W-1:0]      idx;
    logic [DATA_WIDTH-1:0] word;
    logic                  rd_en;
    status_t               status;
    logic [DATA_WIDTH-1:0] rd_sel;

    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign cmd     = cmd_t'(req.data.cmd);
    assign pos_ext = CMP_W'(req.data.position);
    assign cnt_ext = CMP_W'(count_reg);
    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign word    = DATA_WIDTH'($unsigned(req.data.value));

    always_comb
    begin
        op         = CELL_HOLD;
        idx        = '0;
        rd_en      = 1'b0;
        status     = ST_OK;
        count_next = count_reg;
        unique case (cmd)
            CMD_PUSH_BACK, CMD_PUSH_FRONT:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    op         = CELL_INSERT;
                    idx        = (cmd == CMD_PUSH_BACK) ? count_reg[IDX_W-1:0] : '0;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_POP_BACK, CMD_POP_FRONT:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    op         = CELL_REMOVE;
                    idx        = (cmd == CMD_POP_BACK) ?
                                 IDX_W'(count_reg - CNT_W'(1)) : '0;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            CMD_INSERT:
            begin
                if (pos_ext > cnt_ext)
                begin
                    status = ST_BADIDX;
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    op         = CELL_INSERT;
                    idx        = pos_ext[IDX_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_ERASE, CMD_READ:
            begin
                idx = pos_ext[IDX_W-1:0];
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else if (pos_ext >= cnt_ext)
                begin
                    status = ST_BADIDX;
                end
                else if (cmd == CMD_ERASE)
                begin
                    op         = CELL_REMOVE;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    rd_en = 1'b1;
                end
            end
            default:
            begin
                // unused code: no operation
                status = ST_OK;
            end
        endcase
    end

    // cells only move on a request transfer
    always_comb
    begin
        cell_op = CELL_HOLD;
        if (accept)
        begin
            cell_op = op;
        end
    end

    // the chain of cells; ends see zero from outside
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left;
        logic [DATA_WIDTH-1:0] right;

        if (g == 0)
        begin : g_first
            assign left = '0;
        end
        else
        begin : g_mid_l
            assign left = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right = '0;
        end
        else
        begin : g_mid_r
            assign right = cell_data[g+1];
        end

        sal_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IDX_W),
            .INDEX      (g)
        ) u_cell (
            .clk     (clk),
            .op      (cell_op),
            .idx     (idx),
            .word    (word),
            .left    (left),
            .right   (right),
            .data    (cell_data[g]),
            .rd_data (cell_rd[g])
        );
    end

    // one-hot select: only the addressed cell drives non-zero
    always_comb
    begin
        rd_sel = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_sel = rd_sel | cell_rd[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg.read_value <= rd_en ? signed'(32'(rd_sel)) : '0;
            out_reg.count      <= 7'(count_next);
            out_reg.status     <= status;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("element count above capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == CELL_INSERT) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the list by one");

    a_fail_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status != ST_OK) |=> count_reg == $past(count_reg))
        else $error("failed command changed the count");

    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != ST_OK) |-> out_reg.read_value == '0)
        else $error("non-zero read value on a failed command");

    a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_reg.count == 7'(count_reg))
        else $error("result count differs from list count");

endmodule

`default_nettype wire
